/* hw/rtl/msia_pkg.sv */
`timescale 1ns / 1ps
package msia_pkg;
  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned SHW = $clog2(WORD_WIDTH);
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_BITS = WORD_WIDTH / DIV_STAGES;

  localparam logic [4:0] OP_MUL = 5'd0;
  localparam logic [4:0] OP_DIV = 5'd1;
  localparam logic [4:0] OP_MOD = 5'd2;
  localparam logic [4:0] OP_ADD = 5'd3;
  localparam logic [4:0] OP_SUB = 5'd4;
  localparam logic [4:0] OP_SHL = 5'd5;
  localparam logic [4:0] OP_SHR = 5'd6;
  localparam logic [4:0] OP_AND = 5'd7;
  localparam logic [4:0] OP_XOR = 5'd8;
  localparam logic [4:0] OP_OR  = 5'd9;
  localparam logic [4:0] OP_LAND = 5'd10;
  localparam logic [4:0] OP_LOR = 5'd11;
  localparam logic [4:0] OP_NE  = 5'd12;
  localparam logic [4:0] OP_EQ  = 5'd13;
  localparam logic [4:0] OP_GT  = 5'd14;
  localparam logic [4:0] OP_GE  = 5'd15;
  localparam logic [4:0] OP_LT  = 5'd16;
  localparam logic [4:0] OP_LE  = 5'd17;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_DIV0 = 3'd2;
  localparam logic [2:0] ST_DIVOV = 3'd3;
  localparam logic [2:0] ST_BADOP = 3'd4;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [31:0] left_value;
    logic        left_signed;
    logic [31:0] right_value;
    logic        right_signed;
  } req_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        result_signed;
    logic [2:0]  status;
  } rsp_t;

  // per-item control carried alongside the divider
  typedef struct packed {
    logic                  is_div;
    logic                  neg_res;
    logic [WORD_WIDTH-1:0] fast;
    logic                  sgn;
    logic [2:0]            status;
  } ctl_t;
endpackage

/* hw/rtl/msia_front.sv */
`timescale 1ns / 1ps
// Stage 1 logic: decode, promotion check, all non-divide ops, divider setup.
module msia_front (
  input  msia_pkg::req_t                    req,
  output msia_pkg::ctl_t                    ctl,
  output logic [msia_pkg::WORD_WIDTH-1:0]   mag_a,
  output logic [msia_pkg::WORD_WIDTH-1:0]   mag_b
);
  import msia_pkg::*;
  localparam int unsigned W = WORD_WIDTH;

  logic [W-1:0] a, b, smax, r;
  logic as, bs, sgn, lt_ab, lt_ba, big_b;
  logic [2:0] st;

  always_comb begin
    a = req.left_value[W-1:0];
    b = req.right_value[W-1:0];
    as = req.left_signed;
    bs = req.right_signed;
    smax = {1'b0, {(W-1){1'b1}}};
    st = ST_OK;
    if ((as && !bs && b > smax) || (bs && !as && a > smax)) st = ST_CONV;
    sgn = as || bs;
    lt_ab = sgn ? ($signed(a) < $signed(b)) : (a < b);
    lt_ba = sgn ? ($signed(b) < $signed(a)) : (b < a);
    big_b = (b >= W[W-1:0]) || (W > 32 && b[W-1:SHW] != '0);
    mag_a = (sgn && a[W-1]) ? (~a + 1'b1) : a;
    mag_b = (sgn && b[W-1]) ? (~b + 1'b1) : b;
    r = '0;
    ctl.is_div = 1'b0;
    ctl.neg_res = 1'b0;
    case (req.req_type)
      OP_MUL: r = a * b;
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          st = ST_DIV0; sgn = 1'b0;
        end else if (sgn && b == '1 && a == {1'b1, {(W-1){1'b0}}}) begin
          st = ST_DIVOV; sgn = 1'b0;
        end else begin
          // opcode rides in the fast field to pick quotient or remainder
          r = W'(req.req_type);
          ctl.is_div = 1'b1;
          ctl.neg_res = (req.req_type == OP_DIV) ? (sgn && (a[W-1] != b[W-1]))
                                                 : (sgn && a[W-1]);
        end
      end
      OP_ADD: r = a + b;
      OP_SUB: begin
        r = a - b;
        if (!sgn) begin
          if (a > smax || b > smax) st = ST_CONV;
          if (b > a) sgn = 1'b1;
        end
      end
      OP_SHL: r = big_b ? '0 : (a << b[SHW-1:0]);
      OP_SHR: begin
        if (sgn) r = big_b ? {W{a[W-1]}} : W'($signed(a) >>> b[SHW-1:0]);
        else r = big_b ? '0 : (a >> b[SHW-1:0]);
      end
      OP_AND: r = a & b;
      OP_XOR: r = a ^ b;
      OP_OR:  r = a | b;
      OP_LAND: r = W'((a != '0) && (b != '0));
      OP_LOR:  r = W'((a != '0) || (b != '0));
      OP_NE: r = W'(a != b);
      OP_EQ: r = W'(a == b);
      OP_GT: r = W'(lt_ba);
      OP_GE: r = W'(!lt_ab);
      OP_LT: r = W'(lt_ab);
      OP_LE: r = W'(!lt_ba);
      default: begin
        st = ST_BADOP; sgn = 1'b0;
      end
    endcase
    ctl.fast = r;
    ctl.sgn = sgn;
    ctl.status = st;
  end
endmodule

/* hw/rtl/msia_div_step.sv */
`timescale 1ns / 1ps
// DIV_BITS restoring steps of the unsigned divider.
module msia_div_step (
  input  logic [msia_pkg::WORD_WIDTH-1:0] rem_in,
  input  logic [msia_pkg::WORD_WIDTH-1:0] quo_in,
  input  logic [msia_pkg::WORD_WIDTH-1:0] dvs,
  output logic [msia_pkg::WORD_WIDTH-1:0] rem_out,
  output logic [msia_pkg::WORD_WIDTH-1:0] quo_out
);
  import msia_pkg::*;
  logic [WORD_WIDTH:0] t;
  logic [WORD_WIDTH-1:0] rr, qq;
  always_comb begin
    rr = rem_in;
    qq = quo_in;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {rr, qq[WORD_WIDTH-1]};
      qq = {qq[WORD_WIDTH-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
        qq[0] = 1'b1;
      end
      rr = t[WORD_WIDTH-1:0];
    end
    rem_out = rr;
    quo_out = qq;
  end
endmodule

/* hw/rtl/mixed_sign_integer_alu.sv */
`timescale 1ns / 1ps
// Tagged integer ALU, fully pipelined: one beat in per cycle unless the output
// stalls. Stage 1 decodes, checks promotion and computes all non-divide ops;
// DIV_STAGES stages of DIV_BITS restoring steps run the shared-width unsigned
// divider on operand magnitudes; the final stage fixes signs and picks the
// result. A stall freezes the whole pipe, so throughput is set only by the
// output side. Every opcode passes through all stages.
module mixed_sign_integer_alu (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  msia_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output msia_pkg::rsp_t  out_data
);
  import msia_pkg::*;
  localparam int unsigned W = WORD_WIDTH;
  localparam int unsigned N = DIV_STAGES + 1;

  logic adv;
  logic [N-1:0] vld;
  ctl_t ctl [N];
  logic [W-1:0] rem [N];
  logic [W-1:0] quo [N];
  logic [W-1:0] dvs [DIV_STAGES];
  ctl_t ctl_in;
  logic [W-1:0] ma, mb;
  logic [W-1:0] rem_nx [DIV_STAGES];
  logic [W-1:0] quo_nx [DIV_STAGES];
  logic [W-1:0] dres, fin;
  logic out_v;

  // pipe moves when the last slot is empty or being taken
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  msia_front u_front (.req(in_data), .ctl(ctl_in), .mag_a(ma), .mag_b(mb));

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    msia_div_step u_step (
      .rem_in(rem[s]), .quo_in(quo[s]), .dvs(dvs[s]),
      .rem_out(rem_nx[s]), .quo_out(quo_nx[s])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[0] <= ctl_in;
      rem[0] <= '0;
      quo[0] <= ma;
      dvs[0] <= mb;
      for (int s = 1; s < N; s++) begin
        ctl[s] <= ctl[s-1];
        rem[s] <= rem_nx[s-1];
        quo[s] <= quo_nx[s-1];
        if (s < DIV_STAGES) dvs[s] <= dvs[s-1];
      end
    end
  end

  // sign fixup and final select, registered into the output slot
  always_comb begin
    dres = (ctl[N-1].fast == W'(OP_DIV)) ? quo[N-1] : rem[N-1];
    dres = (ctl[N-1].neg_res) ? (~dres + 1'b1) : dres;
    fin = ctl[N-1].is_div ? dres : ctl[N-1].fast;
  end

  // the fast field of a divide holds its opcode
  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (adv) out_v <= vld[N-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.result_value <= 32'(fin);
      out_data.result_signed <= ctl[N-1].sgn;
      out_data.status <= ctl[N-1].status;
    end
  end
  assign out_valid = out_v;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_DIV0 || out_data.status == ST_DIVOV ||
    out_data.status == ST_BADOP) |-> out_data.result_value == '0 &&
    !out_data.result_signed) else $error("error beat carries a value");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output changed");
  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("accept during stall");
`endif
endmodule

/* tb/mixed_sign_integer_alu_tb.sv */
`timescale 1ns / 1ps
module mixed_sign_integer_alu_tb;
  import msia_pkg::*;

  localparam logic [31:0] SMIN_W = 32'h8000_0000;
  localparam logic [31:0] SMAX_W = 32'h7FFF_FFFF;
  localparam logic [31:0] ONES_W = 32'hFFFF_FFFF;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  mixed_sign_integer_alu dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // stimulus waiting to be sent, and predicted results in order
  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  bit   stim_done = 0;
  int   beats_in = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Predicts one ALU beat. Operands get promoted to the common signedness,
  // errors (div by zero, min / -1, bad opcode) zero the value and the tag.
  function automatic rsp_t alu_predict(req_t q);
    rsp_t r;
    logic [31:0] a, b, ma, mb, v;
    logic sgn, a_neg, b_neg;
    logic [2:0] st;
    logic lt_ab, lt_ba;
    a = q.left_value;
    b = q.right_value;
    st = ST_OK;
    if (q.left_signed && !q.right_signed && b > SMAX_W) st = ST_CONV;
    if (q.right_signed && !q.left_signed && a > SMAX_W) st = ST_CONV;
    sgn = q.left_signed | q.right_signed;
    a_neg = a[31];
    b_neg = b[31];
    lt_ab = sgn ? ($signed(a) < $signed(b)) : (a < b);
    lt_ba = sgn ? ($signed(b) < $signed(a)) : (b < a);
    v = '0;
    case (q.req_type)
      OP_MUL: v = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          r.result_value = '0; r.result_signed = 1'b0; r.status = ST_DIV0;
          return r;
        end
        if (sgn && b == ONES_W && a == SMIN_W) begin
          r.result_value = '0; r.result_signed = 1'b0; r.status = ST_DIVOV;
          return r;
        end
        if (sgn) begin
          ma = a_neg ? -a : a;
          mb = b_neg ? -b : b;
          if (q.req_type == OP_DIV) begin
            v = ma / mb;
            if (a_neg != b_neg) v = -v;
          end else begin
            v = ma % mb;
            if (a_neg) v = -v;
          end
        end else begin
          v = (q.req_type == OP_DIV) ? a / b : a % b;
        end
      end
      OP_ADD: v = a + b;
      OP_SUB: begin
        v = a - b;
        if (!sgn) begin
          if (a > SMAX_W || b > SMAX_W) st = ST_CONV;
          if (b > a) sgn = 1'b1;
        end
      end
      OP_SHL: v = (b >= 32) ? '0 : a << b[4:0];
      OP_SHR: begin
        if (b >= 32) v = (sgn && a_neg) ? ONES_W : '0;
        else if (sgn) v = $signed(a) >>> b[4:0];
        else v = a >> b[4:0];
      end
      OP_AND: v = a & b;
      OP_XOR: v = a ^ b;
      OP_OR: v = a | b;
      OP_LAND: v = {31'd0, (a != 0 && b != 0)};
      OP_LOR: v = {31'd0, (a != 0 || b != 0)};
      OP_NE: v = {31'd0, a != b};
      OP_EQ: v = {31'd0, a == b};
      OP_GT: v = {31'd0, lt_ba};
      OP_GE: v = {31'd0, !lt_ab};
      OP_LT: v = {31'd0, lt_ab};
      OP_LE: v = {31'd0, !lt_ba};
      default: begin
        r.result_value = '0; r.result_signed = 1'b0; r.status = ST_BADOP;
        return r;
      end
    endcase
    r.result_value = v;
    r.result_signed = sgn;
    r.status = st;
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2: return ONES_W;
      3: return SMIN_W;
      4: return SMAX_W;
      5: return $urandom_range(0, 40);
      6: return -$urandom_range(1, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t mk_req(logic [4:0] op, logic [31:0] a, logic as_, logic [31:0] b,
                                  logic bs);
    req_t q;
    q.req_type = op;
    q.left_value = a;
    q.left_signed = as_;
    q.right_value = b;
    q.right_signed = bs;
    return q;
  endfunction

  initial begin
    req_t q;
    // directed: extremes, every opcode, each error case
    pending_reqs.push_back(mk_req(OP_DIV, 32'd5, 1'b0, 32'd0, 1'b0));
    pending_reqs.push_back(mk_req(OP_MOD, SMIN_W, 1'b1, 32'd0, 1'b1));
    pending_reqs.push_back(mk_req(OP_DIV, SMIN_W, 1'b1, ONES_W, 1'b1));
    pending_reqs.push_back(mk_req(OP_MOD, SMIN_W, 1'b1, ONES_W, 1'b0));
    pending_reqs.push_back(mk_req(OP_DIV, SMIN_W, 1'b0, ONES_W, 1'b0));
    pending_reqs.push_back(mk_req(OP_DIV, -32'd7, 1'b1, 32'd2, 1'b1));
    pending_reqs.push_back(mk_req(OP_MOD, -32'd7, 1'b1, 32'd2, 1'b0));
    pending_reqs.push_back(mk_req(OP_SUB, 32'd3, 1'b0, 32'd5, 1'b0));
    pending_reqs.push_back(mk_req(OP_SUB, ONES_W, 1'b0, 32'd1, 1'b0));
    pending_reqs.push_back(mk_req(OP_ADD, SMAX_W, 1'b1, 32'd1, 1'b1));
    pending_reqs.push_back(mk_req(OP_MUL, ONES_W, 1'b0, ONES_W, 1'b1));
    pending_reqs.push_back(mk_req(OP_SHL, 32'd1, 1'b0, 32'd31, 1'b0));
    pending_reqs.push_back(mk_req(OP_SHL, 32'd1, 1'b0, 32'd32, 1'b0));
    pending_reqs.push_back(mk_req(OP_SHR, SMIN_W, 1'b1, 32'd32, 1'b0));
    pending_reqs.push_back(mk_req(OP_SHR, SMIN_W, 1'b1, ONES_W, 1'b1));
    pending_reqs.push_back(mk_req(OP_SHR, SMIN_W, 1'b0, 32'd4, 1'b0));
    pending_reqs.push_back(mk_req(OP_SHR, SMIN_W, 1'b1, 32'd4, 1'b0));
    for (int op = OP_AND; op <= OP_LE; op++)
      pending_reqs.push_back(mk_req(op[4:0], ONES_W, 1'b1, 32'd0, 1'b0));
    pending_reqs.push_back(mk_req(5'd31, ONES_W, 1'b1, ONES_W, 1'b0));
    // random: mostly valid opcodes, a few illegal ones
    for (int i = 0; i < 450; i++) begin
      q.req_type = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                                : 5'($urandom_range(0, 17));
      q.left_value = pick_operand();
      q.right_value = pick_operand();
      q.left_signed = 1'($urandom_range(0, 1));
      q.right_signed = 1'($urandom_range(0, 1));
      pending_reqs.push_back(q);
    end
  end

  // driver: holds each beat until accepted, random gap before the next
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(alu_predict(in_data));
        beats_in <= beats_in + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_reqs.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
          // long runs without gaps mixed with sparse traffic
          send_gap <= (beats_in % 100 < 40) ? 0 : $urandom_range(0, 5);
        end else begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor: random stalls plus one long hold-off so the pipe backs up
  int rcv_gap = 0;
  int holdoff = 0;
  bit holdoff_used = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rcv_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected beat: value %h", out_data.result_value);
          errors++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (out_data.result_value !== e.result_value) begin
            $error("result_value exp %h got %h", e.result_value, out_data.result_value);
            errors++;
          end
          if (out_data.result_signed !== e.result_signed) begin
            $error("result_signed exp %b got %b", e.result_signed, out_data.result_signed);
            errors++;
          end
          if (out_data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status);
            errors++;
          end
        end
      end
      if (!holdoff_used && beats_in >= 60) begin
        holdoff_used <= 1'b1;
        holdoff <= 60;
        out_ready <= 1'b0;
      end else if (holdoff > 0) begin
        holdoff <= holdoff - 1;
        out_ready <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap <= rcv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rcv_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 5) : 0;
      end
    end
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && expected_rsps.size() == 0);
    // run on a while so that stray beats would still be caught
    repeat (4 * (DIV_STAGES + 2)) @(posedge clk);
    if (errors == 0) $display("mixed_sign_integer_alu verification clean");
    else $display("mixed_sign_integer_alu verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("mixed_sign_integer_alu verification failed");
    $finish;
  end
endmodule

/* mixed_sign_integer_alu.f */
hw/rtl/msia_pkg.sv
hw/rtl/msia_front.sv
hw/rtl/msia_div_step.sv
hw/rtl/mixed_sign_integer_alu.sv
tb/mixed_sign_integer_alu_tb.sv
